// ----- rtl/prefetch_request_scheduler_assert.svh -----
// Assertion macros used by the scheduler controller (prs_ctrl).
// The module that uses them provides clk and rst_n in scope.
`ifndef PREFETCH_REQUEST_SCHEDULER_ASSERT_SVH
`define PREFETCH_REQUEST_SCHEDULER_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked only while reset is released.
`define PRS_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
  else $error("prefetch scheduler assertion failed");
// Property checked at every edge, reset included.
`define PRS_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("prefetch scheduler assertion failed");
`else
`define PRS_ASSERT(lbl, prop)
`define PRS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- rtl/prs_pkg.sv -----
`timescale 1ns / 1ps
package prs_pkg;

  localparam int PEND_DEPTH = 16;
  localparam int HINT_DEPTH = 24;
  localparam int PIDX_W = $clog2(PEND_DEPTH);
  localparam int HIDX_W = $clog2(HINT_DEPTH);
  localparam int SCAN_W = (PIDX_W > HIDX_W) ? PIDX_W : HIDX_W;

  // Opcodes of an input word.
  localparam logic [3:0] OP_REQ    = 4'd0;
  localparam logic [3:0] OP_HINT   = 4'd1;
  localparam logic [3:0] OP_SST    = 4'd2;
  localparam logic [3:0] OP_SPH    = 4'd3;
  localparam logic [3:0] OP_TAKE   = 4'd4;
  localparam logic [3:0] OP_FINISH = 4'd5;
  localparam logic [3:0] OP_CANCEL = 4'd6;
  localparam logic [3:0] OP_QUERY  = 4'd7;
  localparam logic [3:0] OP_CHECK  = 4'd8;

  // Priorities.
  localparam logic [1:0] PRIO_PREDICTED = 2'd1;
  localparam logic [1:0] PRIO_EXPLICIT  = 2'd2;
  localparam logic [1:0] PRIO_BAD       = 2'd3;

  localparam logic [31:0] EPOCH_EXPLICIT = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_INVAL = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_PSCAN,
    CMD_HSCAN,
    CMD_DROP,
    CMD_HLOAD,
    CMD_COMMIT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    in_rdy;
  } prs_cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       in_valid;
    logic       plast;
    logic       hlast;
    logic       hint_hit;
    logic       out_free;
  } prs_stat_t;

endpackage

// ----- rtl/prs_req_if.sv -----
`timescale 1ns / 1ps
interface prs_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [15:0] clip_id;
  logic [15:0] path_tag;
  logic [31:0] expected_crc;
  logic [1:0]  prio_level;
  logic [7:0]  ctx_state;
  logic [7:0]  ctx_phase;
  logic        keep_valid;

  modport source (output valid, opcode, clip_id, path_tag, expected_crc, prio_level,
                  ctx_state, ctx_phase, keep_valid, input ready);
  modport sink (input valid, opcode, clip_id, path_tag, expected_crc, prio_level,
                ctx_state, ctx_phase, keep_valid, output ready);
endinterface

// ----- rtl/prs_res_if.sv -----
`timescale 1ns / 1ps
interface prs_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        granted;
  logic [15:0] out_clip;
  logic [15:0] out_path;
  logic [31:0] out_crc;
  logic [1:0]  out_prio;
  logic        is_pending;
  logic        is_cancelled;

  modport source (output valid, status, granted, out_clip, out_path, out_crc, out_prio,
                  is_pending, is_cancelled, input ready);
  modport sink (input valid, status, granted, out_clip, out_path, out_crc, out_prio,
                is_pending, is_cancelled, output ready);
endinterface

// ----- rtl/prs_datapath.sv -----
`timescale 1ns / 1ps
module prs_datapath (
  input  logic              clk,
  input  logic              rst_n,
  prs_req_if.sink           in_req,
  prs_res_if.source         out_res,
  input  prs_pkg::prs_cmd_t cmd,
  output prs_pkg::prs_stat_t stat
);
  import prs_pkg::*;

  // Operand registers of the word in work.
  logic [3:0]  op_r;
  logic [15:0] clip_r;
  logic [15:0] path_r;
  logic [31:0] crc_r;
  logic [1:0]  prio_r;
  logic        keep_r;
  logic [15:0] key_r;
  logic [SCAN_W-1:0] idx_r;

  // Pending and hint tables.
  logic        pend_valid_r [PEND_DEPTH];
  logic [15:0] pend_clip_r  [PEND_DEPTH];
  logic [15:0] pend_path_r  [PEND_DEPTH];
  logic [31:0] pend_crc_r   [PEND_DEPTH];
  logic [1:0]  pend_prio_r  [PEND_DEPTH];
  logic [31:0] pend_epoch_r [PEND_DEPTH];
  logic [31:0] pend_order_r [PEND_DEPTH];
  logic        hint_valid_r [HINT_DEPTH];
  logic [15:0] hint_key_r   [HINT_DEPTH];
  logic [15:0] hint_clip_r  [HINT_DEPTH];
  logic [15:0] hint_path_r  [HINT_DEPTH];
  logic [31:0] hint_crc_r   [HINT_DEPTH];

  // Context and active request.
  logic [31:0] cur_epoch_r;
  logic [31:0] order_r;
  logic [7:0]  cur_state_r;
  logic [7:0]  cur_phase_r;
  logic        act_valid_r;
  logic [15:0] act_clip_r;
  logic [31:0] act_epoch_r;
  logic [1:0]  act_prio_r;
  logic        act_cancel_r;

  // Scan trackers.
  logic              m_hit_r, f_hit_r, b_hit_r, hm_hit_r, hf_hit_r;
  logic [PIDX_W-1:0] m_idx_r, f_idx_r, b_idx_r;
  logic [1:0]        m_prio_r, b_prio_r;
  logic [31:0]       b_order_r, b_epoch_r, b_crc_r;
  logic [15:0]       b_clip_r, b_path_r;
  logic [HIDX_W-1:0] hm_idx_r, hf_idx_r;
  logic [15:0]       h_clip_r, h_path_r;
  logic [31:0]       h_crc_r;

  // Result register.
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic        out_granted_r;
  logic [15:0] out_clip_r;
  logic [15:0] out_path_r;
  logic [31:0] out_crc_r;
  logic [1:0]  out_prio_r;
  logic        out_pend_r;
  logic        out_canc_r;

  logic [PIDX_W-1:0] pidx;
  logic [HIDX_W-1:0] hidx;
  logic        pv, hv;
  logic [15:0] pc;
  logic [1:0]  pp;
  logic        drop_hit;
  logic        hint_op, ctx_op, do_enq;
  logic        enq_inval, enq_act, enq_new, enq_raise;
  status_t     enq_status;
  logic        is_scan_cmd, scan_end;

  logic [1:0]  res_status;
  logic        res_granted;
  logic [15:0] res_clip, res_path;
  logic [31:0] res_crc;
  logic [1:0]  res_prio;
  logic        res_pend, res_canc;

  assign pidx = idx_r[PIDX_W-1:0];
  assign hidx = idx_r[HIDX_W-1:0];
  assign pv = pend_valid_r[pidx];
  assign pc = pend_clip_r[pidx];
  assign pp = pend_prio_r[pidx];
  assign hv = hint_valid_r[hidx];

  assign hint_op = (op_r == OP_HINT);
  assign ctx_op  = (op_r == OP_SST) || (op_r == OP_SPH);
  assign do_enq  = (op_r == OP_REQ) || (ctx_op && hm_hit_r);

  // A cancel drops entries other than the kept clip; a context change drops
  // every entry that is not explicit.
  assign drop_hit = pv && ((op_r == OP_CANCEL) ? (!keep_r || pc != clip_r)
                                               : (pp != PRIO_EXPLICIT));

  // Enqueue decision from the finished pending scan.
  assign enq_inval = (crc_r == 32'd0) || (prio_r == PRIO_BAD);
  assign enq_act   = act_valid_r && (act_clip_r == clip_r);
  assign enq_new   = do_enq && !enq_inval && !enq_act && !m_hit_r && f_hit_r;
  assign enq_raise = do_enq && !enq_inval && !enq_act && m_hit_r && (prio_r > m_prio_r);

  always_comb begin
    if (enq_inval) begin
      enq_status = ST_INVAL;
    end else if (enq_act || m_hit_r || f_hit_r) begin
      enq_status = ST_OK;
    end else begin
      enq_status = ST_FULL;
    end
  end

  // Status toward the controller.
  assign stat.op       = op_r;
  assign stat.in_valid = in_req.valid;
  assign stat.plast    = (idx_r == SCAN_W'(PEND_DEPTH - 1));
  assign stat.hlast    = (idx_r == SCAN_W'(HINT_DEPTH - 1));
  assign stat.hint_hit = hm_hit_r;
  assign stat.out_free = !out_valid_r || out_res.ready;

  assign in_req.ready = cmd.in_rdy;

  assign is_scan_cmd = (cmd.op == CMD_PSCAN) || (cmd.op == CMD_DROP) || (cmd.op == CMD_HSCAN);
  assign scan_end = (cmd.op == CMD_HSCAN) ? stat.hlast : stat.plast;

  // Operand capture, scan index and context registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      op_r        <= OP_REQ;
      cur_epoch_r <= 32'd1;
      cur_state_r <= 8'd0;
      cur_phase_r <= 8'd0;
    end else begin
      if (cmd.op == CMD_LOAD) begin
        op_r <= in_req.opcode;
        if (in_req.opcode == OP_SST) begin
          cur_state_r <= in_req.ctx_state;
          cur_epoch_r <= cur_epoch_r + 32'd1;
        end else if (in_req.opcode == OP_SPH) begin
          cur_phase_r <= in_req.ctx_phase;
          cur_epoch_r <= cur_epoch_r + 32'd1;
        end
      end
      if (is_scan_cmd) begin
        idx_r <= scan_end ? '0 : idx_r + SCAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LOAD) begin
      clip_r <= in_req.clip_id;
      path_r <= in_req.path_tag;
      crc_r  <= in_req.expected_crc;
      prio_r <= in_req.prio_level;
      keep_r <= in_req.keep_valid;
      if (in_req.opcode == OP_SST) begin
        key_r <= {in_req.ctx_state, cur_phase_r};
      end else if (in_req.opcode == OP_SPH) begin
        key_r <= {cur_state_r, in_req.ctx_phase};
      end else begin
        key_r <= {in_req.ctx_state, in_req.ctx_phase};
      end
    end else if (cmd.op == CMD_HLOAD) begin
      clip_r <= h_clip_r;
      path_r <= h_path_r;
      crc_r  <= h_crc_r;
      prio_r <= PRIO_PREDICTED;
    end
  end

  // Scan tracker flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_hit_r  <= 1'b0;
      f_hit_r  <= 1'b0;
      b_hit_r  <= 1'b0;
      hm_hit_r <= 1'b0;
      hf_hit_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        CMD_LOAD: begin
          m_hit_r  <= 1'b0;
          f_hit_r  <= 1'b0;
          b_hit_r  <= 1'b0;
          hm_hit_r <= 1'b0;
          hf_hit_r <= 1'b0;
        end
        CMD_HLOAD: begin
          m_hit_r <= 1'b0;
          f_hit_r <= 1'b0;
          b_hit_r <= 1'b0;
        end
        CMD_PSCAN: begin
          if (pv && pc == clip_r) m_hit_r <= 1'b1;
          if (!pv) f_hit_r <= 1'b1;
          if (pv) b_hit_r <= 1'b1;
        end
        CMD_HSCAN: begin
          if (hv && hint_key_r[hidx] == key_r) hm_hit_r <= 1'b1;
          if (!hv) hf_hit_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Scan tracker payload: first match, first free, best so far.
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_PSCAN) begin
      if (pv && pc == clip_r && !m_hit_r) begin
        m_idx_r  <= pidx;
        m_prio_r <= pp;
      end
      if (!pv && !f_hit_r) begin
        f_idx_r <= pidx;
      end
      if (pv && (!b_hit_r || pp > b_prio_r ||
                 (pp == b_prio_r && pend_order_r[pidx] < b_order_r))) begin
        b_idx_r   <= pidx;
        b_prio_r  <= pp;
        b_order_r <= pend_order_r[pidx];
        b_clip_r  <= pc;
        b_path_r  <= pend_path_r[pidx];
        b_crc_r   <= pend_crc_r[pidx];
        b_epoch_r <= pend_epoch_r[pidx];
      end
    end
    if (cmd.op == CMD_HSCAN) begin
      if (hv && hint_key_r[hidx] == key_r && !hm_hit_r) begin
        hm_idx_r <= hidx;
        h_clip_r <= hint_clip_r[hidx];
        h_path_r <= hint_path_r[hidx];
        h_crc_r  <= hint_crc_r[hidx];
      end
      if (!hv && !hf_hit_r) begin
        hf_idx_r <= hidx;
      end
    end
  end

  // Pending valid bits and order counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PEND_DEPTH; i++) begin
        pend_valid_r[i] <= 1'b0;
      end
      order_r <= 32'd0;
    end else begin
      if (cmd.op == CMD_DROP && drop_hit) begin
        pend_valid_r[pidx] <= 1'b0;
      end
      if (cmd.op == CMD_COMMIT) begin
        if (enq_new) begin
          pend_valid_r[f_idx_r] <= 1'b1;
          order_r <= order_r + 32'd1;
        end
        if (op_r == OP_TAKE && b_hit_r) begin
          pend_valid_r[b_idx_r] <= 1'b0;
        end
      end
    end
  end

  // Pending entry payload.
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_COMMIT) begin
      if (enq_new) begin
        pend_clip_r[f_idx_r]  <= clip_r;
        pend_path_r[f_idx_r]  <= path_r;
        pend_crc_r[f_idx_r]   <= crc_r;
        pend_prio_r[f_idx_r]  <= prio_r;
        pend_epoch_r[f_idx_r] <= (prio_r == PRIO_EXPLICIT) ? EPOCH_EXPLICIT : cur_epoch_r;
        pend_order_r[f_idx_r] <= order_r + 32'd1;
      end else if (enq_raise) begin
        pend_prio_r[m_idx_r] <= prio_r;
      end
    end
  end

  // Hint table: a matching key is overwritten, else the first free slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HINT_DEPTH; i++) begin
        hint_valid_r[i] <= 1'b0;
      end
    end else if (cmd.op == CMD_COMMIT && hint_op && crc_r != 32'd0) begin
      if (hm_hit_r) begin
        hint_valid_r[hm_idx_r] <= 1'b1;
      end else if (hf_hit_r) begin
        hint_valid_r[hf_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_COMMIT && hint_op && crc_r != 32'd0) begin
      if (hm_hit_r) begin
        hint_key_r[hm_idx_r]  <= key_r;
        hint_clip_r[hm_idx_r] <= clip_r;
        hint_path_r[hm_idx_r] <= path_r;
        hint_crc_r[hm_idx_r]  <= crc_r;
      end else if (hf_hit_r) begin
        hint_key_r[hf_idx_r]  <= key_r;
        hint_clip_r[hf_idx_r] <= clip_r;
        hint_path_r[hf_idx_r] <= path_r;
        hint_crc_r[hf_idx_r]  <= crc_r;
      end
    end
  end

  // Active request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r  <= 1'b0;
      act_clip_r   <= 16'd0;
      act_epoch_r  <= 32'd0;
      act_prio_r   <= 2'd0;
      act_cancel_r <= 1'b0;
    end else if (cmd.op == CMD_COMMIT) begin
      if (op_r == OP_TAKE && b_hit_r) begin
        act_valid_r  <= 1'b1;
        act_clip_r   <= b_clip_r;
        act_epoch_r  <= b_epoch_r;
        act_prio_r   <= b_prio_r;
        act_cancel_r <= 1'b0;
      end else if (op_r == OP_FINISH) begin
        act_valid_r  <= 1'b0;
        act_cancel_r <= 1'b0;
      end else if (op_r == OP_CANCEL && act_valid_r && (!keep_r || act_clip_r != clip_r)) begin
        act_cancel_r <= 1'b1;
      end
    end
  end

  // Result word for the opcode in work; unrelated fields stay zero.
  always_comb begin
    res_status  = ST_OK;
    res_granted = 1'b0;
    res_clip    = 16'd0;
    res_path    = 16'd0;
    res_crc     = 32'd0;
    res_prio    = 2'd0;
    res_pend    = 1'b0;
    res_canc    = 1'b0;
    unique case (op_r)
      OP_REQ: res_status = enq_status;
      OP_HINT: begin
        if (crc_r == 32'd0) begin
          res_status = ST_INVAL;
        end else if (!hm_hit_r && !hf_hit_r) begin
          res_status = ST_FULL;
        end
      end
      OP_SST, OP_SPH, OP_FINISH, OP_CANCEL: res_status = ST_OK;
      OP_TAKE: begin
        if (b_hit_r) begin
          res_granted = 1'b1;
          res_clip    = b_clip_r;
          res_path    = b_path_r;
          res_crc     = b_crc_r;
          res_prio    = b_prio_r;
        end else begin
          res_status = ST_EMPTY;
        end
      end
      OP_QUERY: res_pend = (act_valid_r && act_clip_r == clip_r) || m_hit_r;
      OP_CHECK: res_canc = act_valid_r && (act_cancel_r ||
                           (act_prio_r != PRIO_EXPLICIT && act_epoch_r != cur_epoch_r));
      default: res_status = ST_INVAL;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == CMD_COMMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_COMMIT) begin
      out_status_r  <= res_status;
      out_granted_r <= res_granted;
      out_clip_r    <= res_clip;
      out_path_r    <= res_path;
      out_crc_r     <= res_crc;
      out_prio_r    <= res_prio;
      out_pend_r    <= res_pend;
      out_canc_r    <= res_canc;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.status       = out_status_r;
  assign out_res.granted      = out_granted_r;
  assign out_res.out_clip     = out_clip_r;
  assign out_res.out_path     = out_path_r;
  assign out_res.out_crc      = out_crc_r;
  assign out_res.out_prio     = out_prio_r;
  assign out_res.is_pending   = out_pend_r;
  assign out_res.is_cancelled = out_canc_r;

endmodule

// ----- rtl/prs_ctrl.sv -----
`timescale 1ns / 1ps
`include "prefetch_request_scheduler_assert.svh"
module prs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  prs_pkg::prs_stat_t stat,
  output prs_pkg::prs_cmd_t  cmd
);
  import prs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_DROP,
    S_HSCAN,
    S_HDEC,
    S_HLOAD,
    S_PSCAN,
    S_COMMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and command for the datapath.
  always_comb begin
    state_nxt  = state_r;
    cmd.op     = CMD_NONE;
    cmd.in_rdy = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_rdy = 1'b1;
        if (stat.in_valid) begin
          cmd.op    = CMD_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.op == OP_REQ || stat.op == OP_TAKE || stat.op == OP_QUERY) begin
          state_nxt = S_PSCAN;
        end else if (stat.op == OP_SST || stat.op == OP_SPH || stat.op == OP_CANCEL) begin
          state_nxt = S_DROP;
        end else if (stat.op == OP_HINT) begin
          state_nxt = S_HSCAN;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_DROP: begin
        cmd.op = CMD_DROP;
        if (stat.plast) begin
          state_nxt = (stat.op == OP_CANCEL) ? S_COMMIT : S_HSCAN;
        end
      end
      S_HSCAN: begin
        cmd.op = CMD_HSCAN;
        if (stat.hlast) begin
          state_nxt = (stat.op == OP_HINT) ? S_COMMIT : S_HDEC;
        end
      end
      S_HDEC: begin
        state_nxt = stat.hint_hit ? S_HLOAD : S_COMMIT;
      end
      S_HLOAD: begin
        cmd.op    = CMD_HLOAD;
        state_nxt = S_PSCAN;
      end
      S_PSCAN: begin
        cmd.op = CMD_PSCAN;
        if (stat.plast) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.op    = CMD_COMMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `PRS_ASSERT(a_accept_dispatch, (state_r == S_IDLE && stat.in_valid) |=> (state_r == S_DISP))
  `PRS_ASSERT_ALWAYS(a_hload_needs_hit, (state_r == S_HLOAD) |-> stat.hint_hit)
  `PRS_ASSERT(a_drop_ops, (state_r == S_DROP) |-> (stat.op == OP_CANCEL || stat.op == OP_SST || stat.op == OP_SPH))

endmodule

// ----- rtl/prefetch_request_scheduler.sv -----
`timescale 1ns / 1ps
// Each input word yields one result word. Request, take, query
// and cancel walk the 16 pending entries, a hint walks the 24 hint entries,
// a state or phase change walks pending and hints, and pending again when a hint
// matches; finish, check and unknown opcodes walk no table.
// One word is in work at a time; the next is taken the cycle after the result is written.
// Reset (synchronous, rst_n low) clears the valid bits, the active request and context.
module prefetch_request_scheduler (
  input  logic      clk,
  input  logic      rst_n,
  prs_req_if.sink   in_req,
  prs_res_if.source out_res
);
  import prs_pkg::*;

  prs_cmd_t  cmd;
  prs_stat_t stat;

  prs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  prs_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule

// ----- bench/prs_tb_if.sv -----
`timescale 1ns / 1ps
// The block's own interfaces (prs_req_if, prs_res_if) carry both channels.
// This file holds the word types that the bench shares between its modules.
package prs_tb_pkg;
  import prs_pkg::*;

  // One input word as the bench builds it.
  typedef struct packed {
    logic [3:0]  opcode;
    logic [15:0] clip_id;
    logic [15:0] path_tag;
    logic [31:0] expected_crc;
    logic [1:0]  prio_level;
    logic [7:0]  ctx_state;
    logic [7:0]  ctx_phase;
    logic        keep_valid;
  } cmd_word_t;

  // One result word.
  typedef struct packed {
    logic [1:0]  status;
    logic        granted;
    logic [15:0] out_clip;
    logic [15:0] out_path;
    logic [31:0] out_crc;
    logic [1:0]  out_prio;
    logic        is_pending;
    logic        is_cancelled;
  } reply_word_t;
endpackage

// ----- bench/prs_scoreboard.sv -----
`timescale 1ns / 1ps
module prs_scoreboard
  import prs_pkg::*;
  import prs_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  prs_req_if          in_req,
  prs_res_if          out_res,
  output int          fail_count,
  output int          replies_owed
);

  // Shadow copy of the scheduler tables.
  logic        pv  [PEND_DEPTH];
  logic [15:0] pclip [PEND_DEPTH];
  logic [15:0] ppath [PEND_DEPTH];
  logic [31:0] pcrc  [PEND_DEPTH];
  logic [1:0]  pprio [PEND_DEPTH];
  logic [31:0] pepoch [PEND_DEPTH];
  logic [31:0] porder [PEND_DEPTH];
  logic        hv   [HINT_DEPTH];
  logic [15:0] hkey [HINT_DEPTH];
  logic [63:0] hent [HINT_DEPTH];
  logic [31:0] epoch_now, order_now;
  logic [7:0]  state_now, phase_now;
  logic        act_v, act_cxl;
  logic [15:0] act_clip;
  logic [31:0] act_ep;
  logic [1:0]  act_pr;

  reply_word_t owed_replies[$];

  function automatic logic [1:0] add_request(logic [15:0] clip, logic [15:0] path,
                                             logic [31:0] crc, logic [1:0] prio);
    int slot;
    slot = -1;
    if (crc == 0 || prio == PRIO_BAD) return ST_INVAL;
    if (act_v && act_clip == clip) return ST_OK;
    for (int i = 0; i < PEND_DEPTH; i++)
      if (pv[i] && pclip[i] == clip) begin
        if (prio > pprio[i]) pprio[i] = prio;
        return ST_OK;
      end
    for (int i = 0; i < PEND_DEPTH; i++)
      if (!pv[i]) begin
        slot = i;
        break;
      end
    if (slot < 0) return ST_FULL;
    pv[slot] = 1'b1;
    pclip[slot] = clip;
    ppath[slot] = path;
    pcrc[slot] = crc;
    pprio[slot] = prio;
    pepoch[slot] = (prio == PRIO_EXPLICIT) ? EPOCH_EXPLICIT : epoch_now;
    order_now = order_now + 32'd1;
    porder[slot] = order_now;
    return ST_OK;
  endfunction

  function automatic void switch_context(logic [7:0] st, logic [7:0] ph);
    state_now = st;
    phase_now = ph;
    epoch_now = epoch_now + 32'd1;
    for (int i = 0; i < PEND_DEPTH; i++)
      if (pv[i] && pprio[i] != PRIO_EXPLICIT) pv[i] = 1'b0;
    for (int i = 0; i < HINT_DEPTH; i++)
      if (hv[i] && hkey[i] == {st, ph}) begin
        void'(add_request(hent[i][15:0], hent[i][31:16], hent[i][63:32], PRIO_PREDICTED));
        break;
      end
  endfunction

  // Works out the reply to one accepted word and updates the shadow state.
  function automatic reply_word_t schedule_word(cmd_word_t w);
    reply_word_t r;
    int slot, best;
    logic hit;
    r = '0;
    case (w.opcode)
      OP_REQ: r.status = add_request(w.clip_id, w.path_tag, w.expected_crc, w.prio_level);
      OP_HINT: begin
        slot = -1;
        if (w.expected_crc == 0) r.status = ST_INVAL;
        else begin
          for (int i = 0; i < HINT_DEPTH; i++) begin
            if (hv[i] && hkey[i] == {w.ctx_state, w.ctx_phase}) begin
              slot = i;
              break;
            end
            if (slot < 0 && !hv[i]) slot = i;
          end
          if (slot < 0) r.status = ST_FULL;
          else begin
            hv[slot] = 1'b1;
            hkey[slot] = {w.ctx_state, w.ctx_phase};
            hent[slot] = {w.expected_crc, w.path_tag, w.clip_id};
          end
        end
      end
      OP_SST: switch_context(w.ctx_state, phase_now);
      OP_SPH: switch_context(state_now, w.ctx_phase);
      OP_TAKE: begin
        best = -1;
        for (int i = 0; i < PEND_DEPTH; i++) begin
          if (!pv[i]) continue;
          if (best < 0 || pprio[i] > pprio[best] ||
              (pprio[i] == pprio[best] && porder[i] < porder[best]))
            best = i;
        end
        if (best < 0) r.status = ST_EMPTY;
        else begin
          r.granted = 1'b1;
          r.out_clip = pclip[best];
          r.out_path = ppath[best];
          r.out_crc = pcrc[best];
          r.out_prio = pprio[best];
          pv[best] = 1'b0;
          act_v = 1'b1;
          act_clip = pclip[best];
          act_ep = pepoch[best];
          act_pr = pprio[best];
          act_cxl = 1'b0;
        end
      end
      OP_FINISH: begin
        act_v = 1'b0;
        act_cxl = 1'b0;
      end
      OP_CANCEL: begin
        if (act_v && (!w.keep_valid || act_clip != w.clip_id)) act_cxl = 1'b1;
        for (int i = 0; i < PEND_DEPTH; i++)
          if (pv[i] && (!w.keep_valid || pclip[i] != w.clip_id)) pv[i] = 1'b0;
      end
      OP_QUERY: begin
        hit = act_v && act_clip == w.clip_id;
        for (int i = 0; i < PEND_DEPTH; i++)
          if (pv[i] && pclip[i] == w.clip_id) hit = 1'b1;
        r.is_pending = hit;
      end
      OP_CHECK:
        if (act_v)
          r.is_cancelled = act_cxl || (act_pr != PRIO_EXPLICIT && act_ep != epoch_now);
      default: r.status = ST_INVAL;
    endcase
    return r;
  endfunction

  assign replies_owed = owed_replies.size();

  // Predict on every accepted word, compare every accepted reply.
  always @(posedge clk) begin
    cmd_word_t   w;
    reply_word_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < PEND_DEPTH; i++) pv[i] = 1'b0;
      for (int i = 0; i < HINT_DEPTH; i++) hv[i] = 1'b0;
      epoch_now = 1;
      order_now = 0;
      state_now = 0;
      phase_now = 0;
      act_v = 0;
      act_cxl = 0;
      act_clip = 0;
      act_ep = 0;
      act_pr = 0;
      owed_replies.delete();
      fail_count <= 0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        got = {out_res.status, out_res.granted, out_res.out_clip, out_res.out_path,
               out_res.out_crc, out_res.out_prio, out_res.is_pending, out_res.is_cancelled};
        if (owed_replies.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected reply %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = owed_replies.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("ERROR: reply mismatch: st %0d/%0d gr %0d/%0d clip %h/%h path %h/%h crc %h/%h pr %0d/%0d pend %0d/%0d cxl %0d/%0d (exp/got)",
                       want.status, got.status, want.granted, got.granted,
                       want.out_clip, got.out_clip, want.out_path, got.out_path,
                       want.out_crc, got.out_crc, want.out_prio, got.out_prio,
                       want.is_pending, got.is_pending, want.is_cancelled, got.is_cancelled);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_req.valid && in_req.ready) begin
        w = {in_req.opcode, in_req.clip_id, in_req.path_tag, in_req.expected_crc,
             in_req.prio_level, in_req.ctx_state, in_req.ctx_phase, in_req.keep_valid};
        owed_replies.push_back(schedule_word(w));
      end
    end
  end

endmodule

// ----- bench/tb_prefetch_request_scheduler.sv -----
`timescale 1ns / 1ps
module tb_prefetch_request_scheduler;
  import prs_pkg::*;
  import prs_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, replies_owed;
  int   send_gap, sink_stall, quiet_cycles;
  logic timed_out = 1'b0;

  prs_req_if in_req ();
  prs_res_if out_res ();

  always #6 clk = ~clk;

  prefetch_request_scheduler u_top (.clk(clk), .rst_n(rst_n), .in_req(in_req),
                                    .out_res(out_res));

  prs_scoreboard u_check (.clk(clk), .rst_n(rst_n), .in_req(in_req), .out_res(out_res),
                          .fail_count(fail_count), .replies_owed(replies_owed));

  // Small clip pool so duplicates, queries and keeps hit often.
  logic [15:0] clip_pool [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                 16'h1234, 16'h00FF, 16'hA5A5, 16'h7FFF};

  initial begin
    in_req.valid = 0;
    in_req.opcode = OP_REQ;
    in_req.clip_id = 0;
    in_req.path_tag = 0;
    in_req.expected_crc = 0;
    in_req.prio_level = 0;
    in_req.ctx_state = 0;
    in_req.ctx_phase = 0;
    in_req.keep_valid = 0;
    out_res.ready = 0;
    send_gap = 0;
    sink_stall = 0;
  end

  // Receiver stalls at the current rate.
  always @(posedge clk) out_res.ready <= ($urandom_range(99) >= sink_stall);

  // Watchdog on cycles with no accepted word or reply.
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_n && quiet_cycles > 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Valid stays high from one word to the next unless the sender idles.
  task automatic send_word(cmd_word_t w);
    while ($urandom_range(99) < send_gap) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid <= 1'b1;
    {in_req.opcode, in_req.clip_id, in_req.path_tag, in_req.expected_crc,
     in_req.prio_level, in_req.ctx_state, in_req.ctx_phase, in_req.keep_valid} <= w;
    do @(posedge clk); while (!in_req.ready);
  endtask

  task automatic send_op(logic [3:0] op, logic [15:0] clip, logic [31:0] crc,
                         logic [1:0] prio, logic [7:0] st, logic [7:0] ph, logic keep);
    cmd_word_t w;
    w = '{op, clip, ~clip, crc, prio, st, ph, keep};
    send_word(w);
  endtask

  // Random word, biased toward well-formed requests and takes.
  task automatic send_random();
    cmd_word_t w;
    int pick;
    w = cmd_word_t'(84'({$urandom, $urandom, $urandom}));
    pick = $urandom_range(99);
    w.clip_id = ($urandom_range(3) != 0) ? clip_pool[$urandom_range(7)] : w.clip_id;
    w.ctx_state = $urandom_range(3) != 0 ? 8'($urandom_range(2)) : w.ctx_state;
    w.ctx_phase = $urandom_range(3) != 0 ? 8'($urandom_range(2)) : w.ctx_phase;
    if (pick < 35) begin
      w.opcode = OP_REQ;
      if ($urandom_range(9) != 0) w.prio_level = 2'($urandom_range(2));
      if ($urandom_range(19) == 0) w.expected_crc = 0;
      if ($urandom_range(3) == 0) w.clip_id = 16'($urandom);
    end else if (pick < 42) begin
      w.opcode = OP_HINT;
      if ($urandom_range(19) == 0) w.expected_crc = 0;
    end else if (pick < 50) w.opcode = ($urandom_range(1) != 0) ? OP_SST : OP_SPH;
    else if (pick < 68) w.opcode = OP_TAKE;
    else if (pick < 74) w.opcode = OP_FINISH;
    else if (pick < 78) w.opcode = OP_CANCEL;
    else if (pick < 88) w.opcode = OP_QUERY;
    else if (pick < 97) w.opcode = OP_CHECK;
    else w.opcode = 4'($urandom_range(9, 15));
    send_word(w);
  endtask

  // Stop sending and wait until every owed result has come.
  task automatic drain();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bad arguments, full table, ties, context drops, hints, cancels.
    send_op(OP_REQ, 16'h0001, 32'h0, PRIO_EXPLICIT, 0, 0, 0);
    send_op(OP_REQ, 16'h0001, 32'h1, PRIO_BAD, 0, 0, 0);
    for (int i = 0; i < 17; i++)
      send_op(OP_REQ, 16'(i * 4099), 32'hFFFF_FFFF - i, 2'(i % 3), 0, 0, 0);
    send_op(OP_REQ, 16'h0000, 32'h5, PRIO_EXPLICIT, 0, 0, 0);
    send_op(OP_HINT, 16'hBEEF, 32'h0, 0, 8'h01, 8'h00, 0);
    send_op(OP_HINT, 16'hBEEF, 32'hCAFE_F00D, PRIO_BAD, 8'h01, 8'h00, 0);
    send_op(OP_SST, 0, 0, 0, 8'h01, 8'hFF, 0);
    send_op(OP_QUERY, 16'hBEEF, 0, 0, 0, 0, 0);
    send_op(OP_TAKE, 0, 0, 0, 0, 0, 0);
    send_op(OP_SPH, 0, 0, 0, 8'hFF, 8'hFF, 0);
    send_op(OP_CHECK, 0, 0, 0, 0, 0, 0);
    send_op(OP_CANCEL, 16'hBEEF, 0, 0, 0, 0, 1);
    send_op(OP_CHECK, 0, 0, 0, 0, 0, 0);
    send_op(OP_CANCEL, 0, 0, 0, 0, 0, 0);
    send_op(OP_TAKE, 0, 0, 0, 0, 0, 0);
    send_op(OP_FINISH, 0, 0, 0, 0, 0, 0);
    send_op(OP_CHECK, 0, 0, 0, 0, 0, 0);
    send_op(4'hF, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 25; i++)
      send_op(OP_HINT, 16'(i), 32'h10 + i, 0, 8'(i), 8'hA5, 0);

    // Random phases with changing idle rates.
    send_gap = 27;
    sink_stall = 83;
    repeat (600) send_random();
    drain();
    send_gap = 83;
    sink_stall = 27;
    repeat (600) send_random();
    send_gap = 0;
    sink_stall = 0;
    repeat (800) send_random();

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/prs_pkg.sv
rtl/prs_req_if.sv
rtl/prs_res_if.sv
rtl/prs_datapath.sv
rtl/prs_ctrl.sv
rtl/prefetch_request_scheduler.sv
bench/prs_tb_if.sv
bench/prs_scoreboard.sv
bench/tb_prefetch_request_scheduler.sv
